>>> sv/assert_macros.svh
// Assertion helpers; each expects signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

>>> sv/swg_pkg.sv
package swg_pkg;

   localparam int PRICE_W        = 24;
   localparam int OUT_W          = 48;
   localparam int SUM_W          = 56;
   localparam int PERIOD_W       = 7;
   localparam int MAX_PERIOD_DEF = 64;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd6;

   // Shared divider geometry
   localparam int DIV_Q_W   = 64;
   localparam int DIV_D_W   = 30;
   localparam int DIV_CNT_W = 7;
   localparam logic [DIV_CNT_W-1:0] SI_STEPS  = 7'd48;
   localparam logic [DIV_CNT_W-1:0] AVG_STEPS = 7'd56;

   typedef struct packed {
      logic                      start_of_series;
      logic [PRICE_W-1:0]        open_price;
      logic [PRICE_W-1:0]        high_price;
      logic [PRICE_W-1:0]        low_price;
      logic [PRICE_W-1:0]        close_price;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0]   swing_sum;
      logic signed [OUT_W-1:0]   swing_average;
      logic                      average_valid;
      logic                      zero_range;
      logic                      saturated;
   } rsp_type;

   typedef struct packed {
      logic load_bar;
      logic calc1;
      logic calc2;
      logic mul1;
      logic mul2;
      logic div_si_go;
      logic acc;
      logic sum;
      logic div_avg_go;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic start;
      logic zero;
      logic ovf;
      logic div_done;
      logic avg_valid;
   } sts_type;

   function automatic logic [PRICE_W-1:0] abs_diff(input logic [PRICE_W-1:0] p,
                                                   input logic [PRICE_W-1:0] q);
      abs_diff = (p >= q) ? (p - q) : (q - p);
   endfunction

endpackage

>>> sv/swg_ram.sv
module swg_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/swg_div.sv
module swg_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [swg_pkg::DIV_D_W-1:0]    rem_init,
   input  logic [swg_pkg::DIV_Q_W-1:0]    dividend,
   input  logic [swg_pkg::DIV_D_W-1:0]    divisor,
   input  logic [swg_pkg::DIV_CNT_W-1:0]  steps,
   output logic                           done,
   output logic [swg_pkg::DIV_Q_W-1:0]    quotient
);
   import swg_pkg::*;

   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   q_ff, q_in;
   logic [DIV_D_W-1:0]   den_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic                 busy_ff, done_ff;
   logic [DIV_D_W:0]     trial;
   logic                 ge;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, q_ff[DIV_Q_W-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? DIV_D_W'(trial - {1'b0, den_ff}) : DIV_D_W'(trial);
      q_in   = {q_ff[DIV_Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= steps;
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_init;
         q_ff   <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   `include "assert_macros.svh"
   `ASSERT_NEXT(a_done_ends_busy, done_ff, !busy_ff && !done_ff)
endmodule

>>> sv/swg_ctrl.sv
module swg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  swg_pkg::sts_type  sts,
   output swg_pkg::cmd_type  cmd
);
   import swg_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CALC1, S_CALC2, S_MUL1, S_MUL2, S_CHECK, S_DIV_SI,
      S_ACC, S_SUM, S_AVGCHK, S_DIV_AVG, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_bar = 1'b1;
               state_in     = S_CALC1;
            end
         end
         S_CALC1: begin
            cmd.calc1 = 1'b1;
            state_in  = S_CALC2;
         end
         S_CALC2: begin
            cmd.calc2 = 1'b1;
            state_in  = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.start || sts.zero || sts.ovf) begin
               state_in = S_ACC;
            end else begin
               cmd.div_si_go = 1'b1;
               state_in      = S_DIV_SI;
            end
         end
         S_DIV_SI: begin
            if (sts.div_done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_AVGCHK;
         end
         S_AVGCHK: begin
            if (sts.avg_valid) begin
               cmd.div_avg_go = 1'b1;
               state_in       = S_DIV_AVG;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV_AVG: begin
            if (sts.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `include "assert_macros.svh"
   `ASSERT_IMP(a_load_only_free, cmd.out_load, !rsp_valid_ff || rsp_ready)
   `ASSERT_NEXT(a_accept_blocks, req_valid && req_ready, !req_ready)
endmodule

>>> sv/swg_datapath.sv
module swg_datapath #(
   parameter int MAX_PERIOD = swg_pkg::MAX_PERIOD_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [swg_pkg::PERIOD_W-1:0]   csr_write_data,
   input  swg_pkg::req_type               req_data,
   input  swg_pkg::cmd_type               cmd,
   output swg_pkg::sts_type               sts,
   output swg_pkg::rsp_type               rsp_data
);
   import swg_pkg::*;

   localparam int AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
   localparam int NW = $clog2(MAX_PERIOD + 1);
   localparam int CW = NW + 1;
   localparam int MW = (NW > PERIOD_W) ? NW : PERIOD_W;

   logic [PERIOD_W-1:0] period_ff;
   logic [NW-1:0]       n_eff;

   req_type             bar_ff;
   logic [PRICE_W-1:0]  prev_open_ff, prev_low_ff, prev_close_ff;

   logic [PRICE_W-1:0]  a_ff, b_ff, c_ff, d_ff;
   logic signed [27:0]  x2_ff, x2_in;
   logic signed [24:0]  e_s, f_s, g_s;
   logic [AW-1:0]       old_addr_ff;
   logic [CW-1:0]       old_tmp;

   logic [26:0]         r4_in, r4_ff, xmag_ff;
   logic [PRICE_W-1:0]  k_ff;
   logic                neg_ff, zero_ff;
   logic [50:0]         prod_ff;
   logic [57:0]         num_ff;
   logic [28:0]         den_ff;
   logic                ovf;

   logic signed [OUT_W-1:0] acc_ff, acc_in;
   logic                    sat_ff, sat_in;
   logic [48:0]             mag;
   logic signed [49:0]      si, sum50;
   logic signed [SUM_W-1:0] wsum_ff, part_ff, base_sum;
   logic [AW-1:0]           ptr_ff, base_ptr;
   logic [NW-1:0]           bars_ff, base_bars;
   logic [OUT_W-1:0]        rd_data;

   logic                    div_go, div_done;
   logic [DIV_D_W-1:0]      div_rem_init, div_divisor;
   logic [DIV_Q_W-1:0]      div_dividend, div_q;
   logic [DIV_CNT_W-1:0]    div_steps;
   logic                    wneg;
   logic [SUM_W-1:0]        wmag, avg56;
   logic                    avg_valid;
   rsp_type                 rsp_ff;

   // Window length register; clamp to 1..MAX_PERIOD
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_write_enable) begin
         period_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (period_ff == '0) begin
         n_eff = NW'(1);
      end else if (MW'(period_ff) > MW'(MAX_PERIOD)) begin
         n_eff = NW'(MAX_PERIOD);
      end else begin
         n_eff = NW'(period_ff);
      end
   end

   // Window base for this bar: a series start clears it
   assign base_sum  = bar_ff.start_of_series ? '0 : wsum_ff;
   assign base_ptr  = bar_ff.start_of_series ? '0 : ptr_ff;
   assign base_bars = bar_ff.start_of_series ? '0 : bars_ff;

   // Latch the bar at acceptance
   always_ff @(posedge clock) begin
      if (cmd.load_bar) begin
         bar_ff <= req_data;
      end
   end

   // Stage one: differences against the previous bar, oldest ring slot
   always_comb begin
      e_s     = $signed({1'b0, bar_ff.close_price}) - $signed({1'b0, prev_close_ff});
      f_s     = $signed({1'b0, bar_ff.close_price}) - $signed({1'b0, bar_ff.open_price});
      g_s     = $signed({1'b0, prev_close_ff}) - $signed({1'b0, prev_open_ff});
      x2_in   = (28'(e_s) <<< 1) + 28'(f_s) + (28'(g_s) <<< 1);
      old_tmp = CW'(base_ptr) + CW'(MAX_PERIOD) - CW'(n_eff);
      if (old_tmp >= CW'(MAX_PERIOD)) begin
         old_tmp = old_tmp - CW'(MAX_PERIOD);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc1) begin
         a_ff        <= abs_diff(bar_ff.high_price, prev_close_ff);
         b_ff        <= abs_diff(bar_ff.low_price, prev_close_ff);
         c_ff        <= abs_diff(bar_ff.high_price, prev_low_ff);
         d_ff        <= abs_diff(prev_close_ff, prev_open_ff);
         x2_ff       <= x2_in;
         old_addr_ff <= AW'(old_tmp);
      end
   end

   // Stage two: pick the range case, take k and the magnitude of 2x
   always_comb begin
      if (a_ff > b_ff && a_ff > c_ff) begin
         r4_in = {1'b0, a_ff, 2'b00} + {2'b00, b_ff, 1'b0} + {3'b000, d_ff};
      end else if (b_ff > a_ff && b_ff > c_ff) begin
         r4_in = {1'b0, b_ff, 2'b00} + {2'b00, a_ff, 1'b0} + {3'b000, d_ff};
      end else begin
         r4_in = {1'b0, c_ff, 2'b00} + {3'b000, d_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc2) begin
         r4_ff   <= r4_in;
         k_ff    <= (a_ff > b_ff) ? a_ff : b_ff;
         neg_ff  <= x2_ff[27];
         xmag_ff <= x2_ff[27] ? 27'(-x2_ff) : 27'(x2_ff);
         zero_ff <= !bar_ff.start_of_series && (r4_in == '0);
      end
   end

   // Multiply |2x| by k, then scale by 100 and form 3*(4r)
   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         prod_ff <= 51'(xmag_ff) * 51'(k_ff);
      end
      if (cmd.mul2) begin
         num_ff <= {1'b0, prod_ff, 6'b0} + {2'b0, prod_ff, 5'b0} + {5'b0, prod_ff, 2'b0};
         den_ff <= {1'b0, r4_ff, 1'b0} + {2'b0, r4_ff};
      end
   end

   // Quotient would reach 2^48: clip without dividing
   assign ovf = {3'b000, num_ff[57:32]} >= den_ff;

   // Shared divider: swing term or window mean
   assign div_go = cmd.div_si_go | cmd.div_avg_go;
   assign wneg   = wsum_ff[SUM_W-1];
   assign wmag   = wneg ? SUM_W'(-wsum_ff) : SUM_W'(wsum_ff);

   always_comb begin
      if (cmd.div_si_go) begin
         div_rem_init = DIV_D_W'(num_ff[57:32]);
         div_dividend = {num_ff[31:0], 32'b0};
         div_divisor  = DIV_D_W'(den_ff);
         div_steps    = SI_STEPS;
      end else begin
         div_rem_init = '0;
         div_dividend = {wmag, 8'b0};
         div_divisor  = DIV_D_W'(n_eff);
         div_steps    = AVG_STEPS;
      end
   end

   swg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .rem_init (div_rem_init),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_q)
   );

   // Accumulate the swing term with saturation; an empty range adds nothing, a series start clears it
   always_comb begin
      if (zero_ff) begin
         mag = '0;
      end else if (ovf) begin
         mag = 49'h1_0000_0000_0000;
      end else begin
         mag = {1'b0, div_q[47:0]};
      end
      si     = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      sum50  = 50'(acc_ff) + si;
      sat_in = 1'b0;
      acc_in = sum50[OUT_W-1:0];
      if (bar_ff.start_of_series) begin
         acc_in = '0;
      end else if (sum50 > 50'sh7FFF_FFFF_FFFF) begin
         acc_in = {1'b0, {(OUT_W-1){1'b1}}};
         sat_in = 1'b1;
      end else if (sum50 < -50'sh8000_0000_0000) begin
         acc_in = {1'b1, {(OUT_W-1){1'b0}}};
         sat_in = 1'b1;
      end
   end

   swg_ram #(
      .WIDTH (OUT_W),
      .DEPTH (MAX_PERIOD)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.acc),
      .wr_addr (base_ptr),
      .wr_data (acc_in),
      .rd_addr (old_addr_ff),
      .rd_data (rd_data)
   );

   // Control state: history, accumulator and window bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_open_ff  <= '0;
         prev_low_ff   <= '0;
         prev_close_ff <= '0;
         acc_ff        <= '0;
         wsum_ff       <= '0;
         ptr_ff        <= '0;
         bars_ff       <= '0;
      end else if (csr_write_enable) begin
         wsum_ff <= '0;
         ptr_ff  <= '0;
         bars_ff <= '0;
      end else begin
         if (cmd.acc) begin
            acc_ff <= acc_in;
         end
         if (cmd.sum) begin
            wsum_ff <= part_ff + SUM_W'(acc_ff);
            ptr_ff  <= (base_ptr == AW'(MAX_PERIOD - 1)) ? '0 : base_ptr + 1'b1;
            if (base_bars < NW'(MAX_PERIOD)) begin
               bars_ff <= base_bars + 1'b1;
            end else begin
               bars_ff <= base_bars;
            end
            prev_open_ff  <= bar_ff.open_price;
            prev_low_ff   <= bar_ff.low_price;
            prev_close_ff <= bar_ff.close_price;
         end
      end
   end

   // Drop the oldest value once the window is full
   always_ff @(posedge clock) begin
      if (cmd.acc) begin
         sat_ff  <= sat_in;
         part_ff <= (base_bars >= n_eff) ? base_sum - SUM_W'($signed(rd_data)) : base_sum;
      end
   end

   // Result register
   assign avg_valid = bars_ff >= n_eff;
   assign avg56     = wneg ? SUM_W'(-div_q[SUM_W-1:0]) : div_q[SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.swing_sum     <= acc_ff;
         rsp_ff.swing_average <= avg_valid ? avg56[OUT_W-1:0] : '0;
         rsp_ff.average_valid <= avg_valid;
         rsp_ff.zero_range    <= zero_ff;
         rsp_ff.saturated     <= sat_ff;
      end
   end

   assign rsp_data      = rsp_ff;
   assign sts.start     = bar_ff.start_of_series;
   assign sts.zero      = zero_ff;
   assign sts.ovf       = ovf;
   assign sts.div_done  = div_done;
   assign sts.avg_valid = avg_valid;

   `include "assert_macros.svh"
   `ASSERT_IMP(a_bars_bound, cmd.sum, bars_ff <= NW'(MAX_PERIOD))
endmodule

>>> sv/swing_index_accumulator_ma.sv
// Accumulative swing index with a moving average. Each bar transaction yields
// one result transaction: the saturating running sum of the swing index in
// price thousandths with 16 fraction bits, and the truncated mean of the last
// n sums once n exist. The shortest bar path skips both divisions (first bar
// of a series, zero range or clipped term, window not yet full); the longest
// runs the 48-step swing division and the 56-step mean division. Both divisions
// share one bit-serial restoring divider, which sets the rate. A new bar is
// taken while the previous result still waits in the output register. Writing
// the window length clears the average window but keeps the running sum.
module swing_index_accumulator_ma #(
   parameter int MAX_PERIOD = swg_pkg::MAX_PERIOD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  swg_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output swg_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_enable,
   input  logic [swg_pkg::PERIOD_W-1:0]  csr_write_data
);
   import swg_pkg::*;

   cmd_type cmd;
   sts_type sts;

   swg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   swg_datapath #(
      .MAX_PERIOD (MAX_PERIOD)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_data         (rsp_data)
   );
endmodule
